FILE: design/wswt_pkg.sv
package wswt_pkg;

  // field widths
  localparam int SMP_W  = 24;
  localparam int TS_W   = 32;
  localparam int NET_W  = 25;
  localparam int SIG_W  = 24;
  localparam int CNTC_W = 10;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 104;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_HIGH_WIN   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HIGH_SIGMA = 3'd1;
  localparam logic [CFG_AW-1:0] REG_LOW_WIN    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_LOW_SIGMA  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_MIN_COUNT  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_TARE_WIN   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_RECENT_CNT = 3'd6;

  // register reset values
  localparam logic [TS_W-1:0]   RST_HIGH_WIN   = 32'd2000000;
  localparam logic [SIG_W-1:0]  RST_HIGH_SIGMA = 24'd250;
  localparam logic [TS_W-1:0]   RST_LOW_WIN    = 32'd500000;
  localparam logic [SIG_W-1:0]  RST_LOW_SIGMA  = 24'd1000;
  localparam logic [CNTC_W-1:0] RST_MIN_COUNT  = 10'd5;
  localparam logic [TS_W-1:0]   RST_TARE_WIN   = 32'd1000000;
  localparam logic [CNTC_W-1:0] RST_RECENT_CNT = 10'd8;

  typedef struct packed {
    logic [TS_W-1:0]   high_win;
    logic [SIG_W-1:0]  high_sigma;
    logic [TS_W-1:0]   low_win;
    logic [SIG_W-1:0]  low_sigma;
    logic [CNTC_W-1:0] min_count;
    logic [TS_W-1:0]   tare_win;
    logic [CNTC_W-1:0] recent_count;
  } cfg_t;

  // one smoothed entry waiting for the back end
  typedef struct packed {
    logic signed [SMP_W-1:0] smoothed;
    logic [TS_W-1:0]         stamp;
    logic                    store;
  } item_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [SMP_W-1:0] smoothed;
    logic signed [SMP_W-1:0] recent_mean;
    logic signed [NET_W-1:0] net_value;
    logic signed [SMP_W-1:0] tare_now;
    logic                    stable_high;
    logic                    stable_low;
  } res_t;

endpackage

FILE: design/wswt_front.sv
module wswt_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [wswt_pkg::SMP_W-1:0] in_sample,
  input  logic [wswt_pkg::TS_W-1:0]        in_stamp,
  output logic                             q_valid,
  output wswt_pkg::item_t                  q_item,
  input  logic                             q_pop
);
  import wswt_pkg::*;

  logic signed [SMP_W-1:0] prev_r;
  logic                    have_r;
  logic signed [SMP_W:0]   pair_sum;
  logic signed [SMP_W:0]   pair_half;
  item_t                   new_item;
  logic                    push;

  item_t      q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  // pairwise average, truncated toward zero
  assign pair_sum  = {prev_r[SMP_W-1], prev_r} + {in_sample[SMP_W-1], in_sample};
  assign pair_half = (pair_sum + {{SMP_W{1'b0}}, pair_sum[SMP_W]}) >>> 1;

  always_comb begin
    new_item.smoothed = have_r ? pair_half[SMP_W-1:0] : '0;
    new_item.stamp    = in_stamp;
    new_item.store    = have_r;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_r[rp_r];

  // previous sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      have_r <= 1'b0;
    end else if (push) begin
      prev_r <= in_sample;
      have_r <= 1'b1;
    end
  end

  // two-entry queue towards the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= new_item;
  end

endmodule

FILE: design/wswt_div.sv
module wswt_div #(
  parameter int SW = 30,
  parameter int DW = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [SW-1:0]              dividend,
  input  logic [DW-1:0]                     divisor,
  output logic                              done,
  output logic signed [wswt_pkg::SMP_W-1:0] quot
);
  import wswt_pkg::*;

  localparam int CNTW = $clog2(SW + 1);

  logic [SW-1:0]   q_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   div_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt_r;
  logic            run_r;
  logic            done_r;
  logic [SW-1:0]   mag;
  logic [DW:0]     trial;
  logic            fits;

  assign mag   = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
  assign trial = {rem_r, q_r[SW-1]};
  assign fits  = (trial >= {1'b0, div_r});
  assign done  = done_r;
  assign quot  = neg_r ? -q_r[SMP_W-1:0] : q_r[SMP_W-1:0];

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r   <= mag;
        rem_r <= '0;
        div_r <= divisor;
        neg_r <= dividend[SW-1];
        cnt_r <= CNTW'(SW);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= fits ? DW'(trial - {1'b0, div_r}) : trial[DW-1:0];
        q_r   <= {q_r[SW-2:0], fits};
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/wswt_back.sv
module wswt_back #(
  parameter int DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  wswt_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  wswt_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output wswt_pkg::res_t  out_res
);
  import wswt_pkg::*;

  localparam int RING = DEPTH - 1;
  localparam int AW   = (RING > 1) ? $clog2(RING) : 1;
  localparam int CW   = $clog2(DEPTH);
  localparam int DW2  = CW + 1;
  localparam int SW   = SMP_W + CW;
  localparam int SSW  = 2 * SMP_W + CW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WR    = 4'd1;
  localparam logic [3:0] S_SCAN1 = 4'd2;
  localparam logic [3:0] S_DIVS  = 4'd3;
  localparam logic [3:0] S_DIVW  = 4'd4;
  localparam logic [3:0] S_SCAN2 = 4'd5;
  localparam logic [3:0] S_SG1   = 4'd6;
  localparam logic [3:0] S_SG2   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  localparam logic [1:0] SEL_RECENT = 2'd0;
  localparam logic [1:0] SEL_HIGH   = 2'd1;
  localparam logic [1:0] SEL_LOW    = 2'd2;
  localparam logic [1:0] SEL_TARE   = 2'd3;

  logic [3:0]  state_r;
  item_t       item_r;
  logic [AW-1:0] wpos_r;
  logic [CW-1:0] fill_r;
  logic [CW-1:0] idx_r;
  logic [1:0]    sel_r;
  logic signed [SMP_W-1:0] tare_r;

  // ring storage
  logic signed [SMP_W-1:0] mem_val [RING];
  logic [TS_W-1:0]         mem_time [RING];
  logic signed [SMP_W-1:0] rd_v_r;
  logic [TS_W-1:0]         rd_t_r;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic                    issue;

  logic          p1_r;
  logic [AW-1:0] p1_idx_r;
  logic          p2_r;
  logic          mh2_r, ml2_r;
  logic [2*SMP_W-1:0] sqh_r, sql_r;

  // window sums and counts
  logic signed [SW-1:0] sum_r, sum_h, sum_l, sum_t;
  logic [CW-1:0]        cnt_h, cnt_l, cnt_t;
  logic signed [SMP_W-1:0] mean_r, mean_h, mean_l, mean_t;
  logic [SSW-1:0] ss_h, ss_l;
  logic [2*SIG_W-1:0] s2h_r, s2l_r;
  logic [SSW-1:0] lim_h, lim_l;
  logic [SSW-1:0] lim_h_c, lim_l_c;

  logic [TS_W-1:0] dt;
  logic win_h, win_l, win_t, in_rec;
  logic [DW2-1:0] ent_age;
  logic [CNTC_W-1:0] rc_eff;
  logic [CW-1:0] n_c;

  logic signed [SMP_W:0] dh, dl;
  logic [SMP_W-1:0] ah, al;
  logic [2*SMP_W-1:0] sqh_c, sql_c;

  logic div_go, div_done;
  logic signed [SW-1:0] div_num;
  logic [CW-1:0] div_den;
  logic signed [SMP_W-1:0] div_q;

  logic pass_h, pass_l;
  logic signed [SMP_W-1:0] tare_new, recent_c;
  res_t res_c;

  logic out_res_valid_r;
  res_t out_res_r;
  logic fin_fire;

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign out_valid = out_res_valid_r;
  assign out_res   = out_res_r;
  assign fin_fire  = (state_r == S_FIN) && (!out_res_valid_r || out_ready);

  assign issue   = ((state_r == S_SCAN1) || (state_r == S_SCAN2)) && (idx_r < fill_r);
  assign rd_addr = idx_r[AW-1:0];
  assign mem_we  = (state_r == S_WR) && item_r.store;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_val[wpos_r]  <= item_r.smoothed;
      mem_time[wpos_r] <= item_r.stamp;
    end
    rd_v_r <= mem_val[rd_addr];
    rd_t_r <= mem_time[rd_addr];
  end

  // window membership of the entry just read
  assign dt    = item_r.stamp - rd_t_r;
  assign win_h = (dt <= cfg.high_win);
  assign win_l = (dt <= cfg.low_win);
  assign win_t = (dt <= cfg.tare_win);

  // newest-first age of the entry just read
  assign ent_age = (DW2'(wpos_r) > DW2'(p1_idx_r)) ?
                   DW2'(wpos_r) - DW2'(1) - DW2'(p1_idx_r) :
                   DW2'(wpos_r) + DW2'(RING) - DW2'(1) - DW2'(p1_idx_r);

  // number of newest entries averaged: at least one (unless the ring is empty), at most the fill
  assign rc_eff = (cfg.recent_count == '0) ? CNTC_W'(1) : cfg.recent_count;
  assign n_c    = (rc_eff > CNTC_W'(fill_r)) ? fill_r : CW'(rc_eff);
  assign in_rec = (ent_age < DW2'(n_c));

  // deviations from the window means
  assign dh    = (SMP_W + 1)'(rd_v_r) - (SMP_W + 1)'(mean_h);
  assign dl    = (SMP_W + 1)'(rd_v_r) - (SMP_W + 1)'(mean_l);
  assign ah    = dh[SMP_W] ? SMP_W'(-dh) : SMP_W'(dh);
  assign al    = dl[SMP_W] ? SMP_W'(-dl) : SMP_W'(dl);
  assign sqh_c = ah * ah;
  assign sql_c = al * al;

  assign lim_h_c = SSW'(s2h_r) * SSW'(cnt_h);
  assign lim_l_c = SSW'(s2l_r) * SSW'(cnt_l);

  // shared divider
  assign div_go = (state_r == S_DIVS);
  always_comb begin
    case (sel_r)
      SEL_RECENT: begin div_num = sum_r; div_den = n_c;   end
      SEL_HIGH:   begin div_num = sum_h; div_den = cnt_h; end
      SEL_LOW:    begin div_num = sum_l; div_den = cnt_l; end
      default:    begin div_num = sum_t; div_den = cnt_t; end
    endcase
  end

  wswt_div #(.SW(SW), .DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quot     (div_q)
  );

  // stability tests and tare
  assign pass_h = (cnt_h != '0) && (CNTC_W'(cnt_h) >= cfg.min_count) && (ss_h < lim_h);
  assign pass_l = (cnt_l != '0) && (CNTC_W'(cnt_l) >= cfg.min_count) && (ss_l < lim_l);

  always_comb begin
    tare_new = tare_r;
    if ((tare_r == '0) && pass_h) tare_new = (cnt_t == '0) ? '0 : mean_t;
    recent_c          = (fill_r == '0) ? '0 : mean_r;
    res_c.valid_res   = (fill_r != '0);
    res_c.smoothed    = item_r.smoothed;
    res_c.recent_mean = recent_c;
    res_c.net_value   = NET_W'(recent_c) - NET_W'(tare_new);
    res_c.tare_now    = tare_new;
    res_c.stable_high = pass_h;
    res_c.stable_low  = pass_l;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      wpos_r          <= '0;
      fill_r          <= '0;
      tare_r          <= '0;
      idx_r           <= '0;
      sel_r           <= SEL_RECENT;
      p1_r            <= 1'b0;
      p2_r            <= 1'b0;
      out_res_valid_r <= 1'b0;
    end else begin
      p1_r     <= issue;
      p1_idx_r <= rd_addr;
      p2_r     <= p1_r && (state_r == S_SCAN2);
      mh2_r    <= win_h;
      ml2_r    <= win_l;
      sqh_r    <= sqh_c;
      sql_r    <= sql_c;
      if (issue) idx_r <= idx_r + CW'(1);
      if (fin_fire) out_res_valid_r <= 1'b1;
      else if (out_ready) out_res_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            state_r <= S_WR;
          end
        end
        S_WR: begin
          if (item_r.store) begin
            wpos_r <= (DW2'(wpos_r) + DW2'(1) == DW2'(RING)) ? '0 : wpos_r + AW'(1);
            if (fill_r != CW'(RING)) fill_r <= fill_r + CW'(1);
          end
          idx_r   <= '0;
          sum_r   <= '0;
          sum_h   <= '0;
          sum_l   <= '0;
          sum_t   <= '0;
          cnt_h   <= '0;
          cnt_l   <= '0;
          cnt_t   <= '0;
          state_r <= S_SCAN1;
        end
        S_SCAN1: begin
          if (p1_r) begin
            if (in_rec) sum_r <= sum_r + SW'(rd_v_r);
            if (win_h) begin
              sum_h <= sum_h + SW'(rd_v_r);
              cnt_h <= cnt_h + CW'(1);
            end
            if (win_l) begin
              sum_l <= sum_l + SW'(rd_v_r);
              cnt_l <= cnt_l + CW'(1);
            end
            if (win_t) begin
              sum_t <= sum_t + SW'(rd_v_r);
              cnt_t <= cnt_t + CW'(1);
            end
          end else if (!issue) begin
            sel_r   <= SEL_RECENT;
            state_r <= S_DIVS;
          end
        end
        S_DIVS: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            case (sel_r)
              SEL_RECENT: mean_r <= div_q;
              SEL_HIGH:   mean_h <= div_q;
              SEL_LOW:    mean_l <= div_q;
              default:    mean_t <= div_q;
            endcase
            if (sel_r == SEL_TARE) begin
              idx_r   <= '0;
              ss_h    <= '0;
              ss_l    <= '0;
              state_r <= S_SCAN2;
            end else begin
              sel_r   <= sel_r + 2'd1;
              state_r <= S_DIVS;
            end
          end
        end
        S_SCAN2: begin
          if (p2_r) begin
            if (mh2_r) ss_h <= ss_h + SSW'(sqh_r);
            if (ml2_r) ss_l <= ss_l + SSW'(sql_r);
          end
          if (!issue && !p1_r && !p2_r) state_r <= S_SG1;
        end
        S_SG1: begin
          s2h_r   <= cfg.high_sigma * cfg.high_sigma;
          s2l_r   <= cfg.low_sigma * cfg.low_sigma;
          state_r <= S_SG2;
        end
        S_SG2: begin
          lim_h   <= lim_h_c;
          lim_l   <= lim_l_c;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_fire) begin
            out_res_r <= res_c;
            tare_r    <= tare_new;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/windowed_weight_stability_tracker_core.sv
// Channel | Group | Fields (lowest bit first)
// input   | in_   | tdata: sample[23:0], stamp_us[55:24]
// result  | out_  | tdata: valid_res[0], smoothed[24:1], recent_mean[48:25],
//         |       |        net_value[73:49], tare_now[97:74], stable_high[98],
//         |       |        stable_low[99], zero pad[103:100]
// config  | cfg_  | we, addr (register index), wdata
//
// Each item takes two walks of the ring memory through its single read port over
// the F stored entries (F at most DEPTH-1), and four means on the shared serial
// divider, each a start, one quotient step per bit of the 24 + log2(DEPTH) bit
// dividend and a hand-back. A two-entry queue takes new transactions while the back
// end works, until it is full; an output register holds a result until it is taken,
// and the back end waits in its last state meanwhile. Reset is synchronous, active
// low, no clearing.
module windowed_weight_stability_tracker_core #(
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample, stamp_us
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [wswt_pkg::IN_TDATA_W-1:0]       in_tdata,
  // valid_res, smoothed, recent_mean, net_value, tare_now, stable_high, stable_low
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [wswt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_we,
  input  logic [wswt_pkg::CFG_AW-1:0]           cfg_addr,
  input  logic [wswt_pkg::CFG_DW-1:0]           cfg_wdata
);
  import wswt_pkg::*;

  cfg_t  cfg_r;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  res_t  res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_win     <= RST_HIGH_WIN;
      cfg_r.high_sigma   <= RST_HIGH_SIGMA;
      cfg_r.low_win      <= RST_LOW_WIN;
      cfg_r.low_sigma    <= RST_LOW_SIGMA;
      cfg_r.min_count    <= RST_MIN_COUNT;
      cfg_r.tare_win     <= RST_TARE_WIN;
      cfg_r.recent_count <= RST_RECENT_CNT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HIGH_WIN:   cfg_r.high_win     <= cfg_wdata;
        REG_HIGH_SIGMA: cfg_r.high_sigma   <= cfg_wdata[SIG_W-1:0];
        REG_LOW_WIN:    cfg_r.low_win      <= cfg_wdata;
        REG_LOW_SIGMA:  cfg_r.low_sigma    <= cfg_wdata[SIG_W-1:0];
        REG_MIN_COUNT:  cfg_r.min_count    <= cfg_wdata[CNTC_W-1:0];
        REG_TARE_WIN:   cfg_r.tare_win     <= cfg_wdata;
        REG_RECENT_CNT: cfg_r.recent_count <= cfg_wdata[CNTC_W-1:0];
        default: ;
      endcase
    end
  end

  wswt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SMP_W-1:0]),
    .in_stamp  (in_tdata[SMP_W+TS_W-1:SMP_W]),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  wswt_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // result packing, first field lowest
  assign out_tdata = {4'b0, res.stable_low, res.stable_high, res.tare_now,
                      res.net_value, res.recent_mean, res.smoothed, res.valid_res};

endmodule

FILE: design/wswt_checker.sv
module wswt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [55:0]  in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata
);

  // a stalled input transaction stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input transaction changed while stalled");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // empty ring reports a zero mean and no stability
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |->
      (out_tdata[48:25] == 24'd0) && !out_tdata[98] && !out_tdata[99])
    else $error("empty ring reported data");

  // net value is the mean less the reported tare
  a_net: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[73:49] ==
      ({out_tdata[48], out_tdata[48:25]} - {out_tdata[97], out_tdata[97:74]}))
    else $error("net value inconsistent");

endmodule

bind windowed_weight_stability_tracker_core wswt_checker u_wswt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
